// ===== rtl/taa_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle area accumulator package
// Shared widths, constants, the command and status structs and a helper function.
// ----------------------------------------------------------------------------
package taa_pkg;

	// Field widths fixed by the interface.
	localparam int AREA_W     = 48;
	localparam int ROW_W      = 48;
	localparam int ENTRY_W    = 16;
	localparam int CFG_IDX_W  = 2;

	// The shared multiplier is signed and wide enough for every operand.
	localparam int MUL_W      = 34;
	localparam int PROD_W     = 2 * MUL_W;

	// Transformed edge components and cross product magnitudes.
	localparam int EDGE_W     = 31;
	localparam int CROSS_W    = 64;
	localparam int SUM_W      = 128;
	localparam int ROOT_W     = 64;
	localparam int REM_W      = ROOT_W + 2;

	localparam logic signed [PROD_W-1:0] EDGE_LIMIT = PROD_W'(64'sd1073741823);
	localparam logic [AREA_W-1:0]        AREA_MAX   = '1;

	// Square root runs one result bit per cycle.
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

	localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

	// Datapath phase that the multiplier is serving.
	typedef enum logic [1:0] {
		PH_NONE,
		PH_XFORM,
		PH_CROSS,
		PH_SQUARE
	} phase_t;

	typedef struct packed {
		logic       load;
		phase_t     phase;
		logic [2:0] idx;
		logic [1:0] sub;
		logic       mul_en;
		logic       sqrt_en;
		logic       accum;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} status_t;

	// Signed matrix entry k of a packed row.
	function automatic logic signed [ENTRY_W-1:0] mat_entry(input logic [ROW_W-1:0] row,
			input logic [1:0] k);
		mat_entry = row[k * ENTRY_W +: ENTRY_W];
	endfunction

endpackage

// ===== rtl/taa_in_if.sv =====
// ----------------------------------------------------------------------------
// Triangle input channel
// One beat carries three vertices and the skip and last flags.
// ----------------------------------------------------------------------------
interface taa_in_if #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ax;
	logic signed [COORD_BITS-1:0] ay;
	logic signed [COORD_BITS-1:0] az;
	logic signed [COORD_BITS-1:0] bx;
	logic signed [COORD_BITS-1:0] by_coord;
	logic signed [COORD_BITS-1:0] bz;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic signed [COORD_BITS-1:0] cz;
	logic                         skip;
	logic                         last;

	modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, skip, last,
		input ready);
	modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, skip, last,
		output ready);
endinterface

// ===== rtl/taa_out_if.sv =====
// ----------------------------------------------------------------------------
// Area result channel
// One beat carries the triangle area, the running total and two flags.
// ----------------------------------------------------------------------------
interface taa_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] triangle_area;
	logic [47:0] total_area;
	logic        final_res;
	logic        saturated;

	modport source (output valid, triangle_area, total_area, final_res, saturated,
		input ready);
	modport sink (input valid, triangle_area, total_area, final_res, saturated,
		output ready);
endinterface

// ===== rtl/taa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one matrix row register.
// ----------------------------------------------------------------------------
interface taa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [47:0] data;

	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/taa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Triangle area controller
// Sequences transform, cross product, squares, square root and accumulation.
// ----------------------------------------------------------------------------
module taa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  taa_pkg::status_t status,
	output taa_pkg::cmd_t    cmd
);
	import taa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_XFORM,
		S_CROSS,
		S_SQUARE,
		S_SQRT,
		S_ACCUM
	} state_t;

	state_t                state_q;
	logic [2:0]            idx_q;
	logic [1:0]            sub_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  out_valid_q;

	// Command decode from the state and step counters.
	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.sub = sub_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_XFORM: begin
				cmd.phase  = PH_XFORM;
				cmd.mul_en = (idx_q < 3'd6) && !status.skip;
			end
			S_CROSS: begin
				cmd.phase  = PH_CROSS;
				cmd.mul_en = idx_q < 3'd3;
			end
			S_SQUARE: begin
				cmd.phase  = PH_SQUARE;
				cmd.mul_en = idx_q < 3'd3;
			end
			S_SQRT: begin
				cmd.sqrt_en = 1'b1;
			end
			S_ACCUM: begin
				// The output register must be free or emptied at this edge.
				cmd.accum = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// State and step counters. The step past the last product is a bubble that
	// lets the accumulate stage finish before the next phase reads its results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			sub_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accum) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					sub_q <= '0;
					if (in_valid) begin
						state_q <= S_XFORM;
					end
				end
				S_XFORM: begin
					if (status.skip) begin
						state_q <= S_ACCUM;
					end else if (idx_q == 3'd6) begin
						idx_q   <= '0;
						sub_q   <= '0;
						state_q <= S_CROSS;
					end else if (sub_q == 2'd2) begin
						sub_q <= '0;
						idx_q <= idx_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				S_CROSS: begin
					if (idx_q == 3'd3) begin
						idx_q   <= '0;
						sub_q   <= '0;
						state_q <= S_SQUARE;
					end else if (sub_q == 2'd1) begin
						sub_q <= '0;
						idx_q <= idx_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				S_SQUARE: begin
					if (idx_q == 3'd3) begin
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else if (sub_q == 2'd2) begin
						sub_q <= '0;
						idx_q <= idx_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
						state_q <= S_ACCUM;
					end
				end
				S_ACCUM: begin
					if (cmd.accum) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/taa_dp.sv =====
// ----------------------------------------------------------------------------
// Triangle area datapath
// Shared multiplier, accumulators, bit-serial square root and running total.
// ----------------------------------------------------------------------------
module taa_dp #(
	parameter int COORD_BITS       = 24,
	parameter int MATRIX_FRAC_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  taa_pkg::cmd_t                     cmd,
	output taa_pkg::status_t                  status,
	input  logic                              cfg_we,
	input  logic [taa_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [taa_pkg::ROW_W-1:0]         cfg_data,
	input  logic signed [COORD_BITS-1:0]      vtx [9],
	input  logic                              in_skip,
	input  logic                              in_last,
	output logic [taa_pkg::AREA_W-1:0]        triangle_area,
	output logic [taa_pkg::AREA_W-1:0]        total_area,
	output logic                              final_res,
	output logic                              saturated
);
	import taa_pkg::*;

	localparam int EW = COORD_BITS + 1;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (MATRIX_FRAC_BITS - 1);

	logic [ROW_W-1:0]         rows_q [3];
	logic signed [EW-1:0]     u_q [3];
	logic signed [EW-1:0]     w_q [3];
	logic signed [EDGE_W-1:0] t_q [6];
	logic [CROSS_W-1:0]       crm_q [3];
	logic                     skip_q, last_q;
	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod_s1, acc_q, acc_n, rnd, diff;
	cmd_t                     cmd_s1;
	logic [SUM_W-1:0]         sum_q;
	logic [REM_W-1:0]         rem_q, rem_sh, trial;
	logic [ROOT_W-1:0]        root_q;
	logic [AREA_W-1:0]        total_q, area;
	logic                     ovf_q;
	logic [AREA_W:0]          total_sum;
	logic [AREA_W-1:0]        total_n;
	logic                     ovf_n;
	logic [2:0]               mrow;
	logic [2:0]               ai, bi;
	logic [1:0]               row_sel;

	assign status.skip = skip_q;

	// Configuration rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ROW_X_RST;
			rows_q[1] <= ROW_Y_RST;
			rows_q[2] <= ROW_Z_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROW_X: rows_q[0] <= cfg_data;
				REG_ROW_Y: rows_q[1] <= cfg_data;
				REG_ROW_Z: rows_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Cross product operand pairs: first term on sub 0, subtracted term on sub 1.
	always_comb begin
		ai = 3'd0;
		bi = 3'd0;
		unique case ({cmd.idx[1:0], cmd.sub[0]})
			3'b00_0: begin ai = 3'd1; bi = 3'd5; end
			3'b00_1: begin ai = 3'd2; bi = 3'd4; end
			3'b01_0: begin ai = 3'd2; bi = 3'd3; end
			3'b01_1: begin ai = 3'd0; bi = 3'd5; end
			3'b10_0: begin ai = 3'd0; bi = 3'd4; end
			3'b10_1: begin ai = 3'd1; bi = 3'd3; end
			default: begin end
		endcase
	end

	// Multiplier operand selection.
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		mrow    = (cmd.idx < 3'd3) ? cmd.idx : cmd.idx - 3'd3;
		row_sel = mrow[1:0];
		unique case (cmd.phase)
			PH_XFORM: begin
				op_a = MUL_W'(mat_entry(rows_q[row_sel], cmd.sub));
				op_b = (cmd.idx < 3'd3) ? MUL_W'(u_q[cmd.sub]) : MUL_W'(w_q[cmd.sub]);
			end
			PH_CROSS: begin
				op_a = MUL_W'(t_q[ai]);
				op_b = MUL_W'(t_q[bi]);
			end
			PH_SQUARE: begin
				// Low half squared, low times high, high squared.
				op_a = (cmd.sub == 2'd2) ? MUL_W'(crm_q[cmd.idx[1:0]][63:32])
					: MUL_W'(crm_q[cmd.idx[1:0]][31:0]);
				op_b = (cmd.sub == 2'd0) ? MUL_W'(crm_q[cmd.idx[1:0]][31:0])
					: MUL_W'(crm_q[cmd.idx[1:0]][63:32]);
			end
			PH_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// Accumulate-stage arithmetic.
	always_comb begin
		acc_n = ((cmd_s1.sub == 2'd0) ? '0 : acc_q) + prod_s1;
		rnd   = (acc_n + ROUND_HALF) >>> MATRIX_FRAC_BITS;
		if (rnd > EDGE_LIMIT) begin
			rnd = EDGE_LIMIT;
		end else if (rnd < -EDGE_LIMIT) begin
			rnd = -EDGE_LIMIT;
		end
		diff = acc_q - prod_s1;
	end

	// Square root step: bring down two radicand bits, try one root bit.
	assign rem_sh = {rem_q[REM_W-3:0], sum_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	// Area clamp and saturating total.
	always_comb begin
		area      = (|root_q[ROOT_W-1:AREA_W+9]) ? AREA_MAX : root_q[AREA_W+8:9];
		if (skip_q) begin
			area = '0;
		end
		total_sum = {1'b0, total_q} + {1'b0, area};
		total_n   = total_q;
		ovf_n     = ovf_q;
		if (!skip_q) begin
			if (total_sum >= {1'b0, AREA_MAX}) begin
				total_n = AREA_MAX;
				ovf_n   = 1'b1;
			end else begin
				total_n = total_sum[AREA_W-1:0];
			end
		end
	end

	// Multiplier register and delayed command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// Working registers of one triangle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				u_q[i] <= EW'(vtx[3 + i]) - EW'(vtx[i]);
				w_q[i] <= EW'(vtx[6 + i]) - EW'(vtx[i]);
			end
			skip_q <= in_skip;
			last_q <= in_last;
			sum_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			if (cmd_s1.mul_en) begin
				unique case (cmd_s1.phase)
					PH_XFORM: begin
						if (cmd_s1.sub == 2'd2) begin
							t_q[cmd_s1.idx] <= EDGE_W'(rnd);
						end else begin
							acc_q <= acc_n;
						end
					end
					PH_CROSS: begin
						if (cmd_s1.sub == 2'd0) begin
							acc_q <= prod_s1;
						end else begin
							crm_q[cmd_s1.idx[1:0]] <= diff[PROD_W-1] ? CROSS_W'(-diff)
								: CROSS_W'(diff);
						end
					end
					PH_SQUARE: begin
						unique case (cmd_s1.sub)
							2'd0: sum_q <= sum_q + SUM_W'(prod_s1[63:0]);
							2'd1: sum_q <= sum_q + (SUM_W'(prod_s1[63:0]) << 33);
							2'd2: sum_q <= sum_q + (SUM_W'(prod_s1[63:0]) << 64);
							default: begin
							end
						endcase
					end
					PH_NONE: begin
					end
					default: begin
					end
				endcase
			end
			if (cmd.sqrt_en) begin
				sum_q <= sum_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// Mesh total, cleared after the closing triangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.accum) begin
			total_q <= last_q ? '0 : total_n;
			ovf_q   <= last_q ? 1'b0 : ovf_n;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			triangle_area <= area;
			total_area    <= total_n;
			final_res     <= last_q;
			saturated     <= ovf_n;
		end
	end

endmodule

// ===== rtl/triangle_area_accumulator.sv =====
// ----------------------------------------------------------------------------
// Triangle area accumulator
// Transforms each triangle by a 3x3 matrix and sums the transformed areas.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one triangle per beat (three signed vertices, skip, last).
//   out_ch returns one beat per triangle: its area, the running mesh total,
//   the last flag echoed as final_res and the sticky saturation flag.
//   cfg writes matrix row registers (index 0, 1, 2); other indexes are ignored.
//   Write configuration only while no triangle is in flight.
// Sequencing:
//   A triangle runs transform, cross product and square steps on the
//   shared 34x34 multiplier, then the one-bit-a-cycle square root and
//   the accumulate step that registers the result. Input is ready again
//   once the result is registered: one triangle is computed at a time.
//   A skipped triangle bypasses the arithmetic and goes to accumulate.
// Reset clears the controller, the total and the flag, and loads the identity
// matrix. A stalled result holds in the output register; the next triangle is
// still computed and waits in its accumulate state until the result is taken.
// ----------------------------------------------------------------------------
module triangle_area_accumulator #(
	parameter int COORD_BITS       = 24,
	parameter int MATRIX_FRAC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	taa_in_if.sink    in_ch,
	taa_out_if.source out_ch,
	taa_cfg_if.sink   cfg
);
	import taa_pkg::*;

	cmd_t                         cmd;
	status_t                      status;
	logic signed [COORD_BITS-1:0] vtx [9];

	assign cfg.ready = 1'b1;

	assign vtx[0] = in_ch.ax;
	assign vtx[1] = in_ch.ay;
	assign vtx[2] = in_ch.az;
	assign vtx[3] = in_ch.bx;
	assign vtx[4] = in_ch.by_coord;
	assign vtx[5] = in_ch.bz;
	assign vtx[6] = in_ch.cx;
	assign vtx[7] = in_ch.cy;
	assign vtx[8] = in_ch.cz;

	taa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	taa_dp #(
		.COORD_BITS       (COORD_BITS),
		.MATRIX_FRAC_BITS (MATRIX_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg.valid),
		.cfg_idx       (cfg.reg_index),
		.cfg_data      (cfg.data),
		.vtx           (vtx),
		.in_skip       (in_ch.skip),
		.in_last       (in_ch.last),
		.triangle_area (out_ch.triangle_area),
		.total_area    (out_ch.total_area),
		.final_res     (out_ch.final_res),
		.saturated     (out_ch.saturated)
	);

endmodule

// ===== rtl/taa_chk.sv =====
// ----------------------------------------------------------------------------
// Triangle area accumulator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module taa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] triangle_area,
	input logic [47:0] total_area,
	input logic        saturated
);

	// A result beat is held until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(triangle_area) && $stable(total_area))
		else $error("result payload changed while stalled");

	// One triangle is computed at a time: input closes right after a beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after acceptance");

	// A new triangle cannot produce its result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early after acceptance");

	// Without saturation the total includes this triangle's area.
	a_total_ge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !saturated |-> total_area >= triangle_area)
		else $error("total below triangle area");

endmodule

bind triangle_area_accumulator taa_chk u_taa_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.triangle_area (out_ch.triangle_area),
	.total_area    (out_ch.total_area),
	.saturated     (out_ch.saturated)
);
